### src/tql_pkg.sv
// Shared types and constants for the tabular Q-learning engine.
// Used by tql_ctrl, tql_dp and tabular_q_learning_engine; depends on nothing.
`default_nettype none

package tql_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_HISTORY_BITS = 8;
    localparam int DEF_MAX_ACTIONS  = 4;

    // Q values are signed Q11.12.
    localparam int Q_W = 24;
    localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

    // Stream and configuration port widths.
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTION_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEARN_RATE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPLORE_THR  = 2'd3;

    // Configuration reset values.
    localparam logic [2:0]  RST_ACTION_COUNT = 3'd2;
    localparam logic [15:0] RST_LEARN_RATE   = 16'd6554;
    localparam logic [15:0] RST_DISCOUNT     = 16'd62259;
    localparam logic [16:0] RST_EXPLORE_THR  = 17'd6554;

    // Operation codes carried in tuser.
    localparam logic OP_CHOOSE = 1'b0;
    localparam logic OP_LEARN  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic rd_one;
        logic capture;
        logic mul1;
        logic mul2;
        logic write;
        logic emit;
    } tql_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_learn;
        logic explore;
        logic taken_ok;
        logic ep_done;
        logic scan_last;
        logic out_busy;
    } tql_stat_t;

endpackage

`default_nettype wire

### src/tabular_q_learning_engine.sv
// Tabular Q-learning engine: epsilon-greedy choice and one-step Q update.
// Explore reads one entry; greedy choose scans the row; learn scans the next row
// (not at episode end), reads, multiplies and writes; out-of-range learn actions
// go straight to output. A new item is taken once the result is registered.
// The row maximum scan reads one table entry per cycle over the single read port.
// After reset a clearing pass zeroes the 2^(HISTORY_BITS+log2(MAX_ACTIONS))
// entries (1024 by default) with s_tready low; config is accepted.
`default_nettype none

module tabular_q_learning_engine #(
    parameter int HISTORY_BITS = tql_pkg::DEF_HISTORY_BITS,
    parameter int MAX_ACTIONS  = tql_pkg::DEF_MAX_ACTIONS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tql_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tql_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: state_history[7:0], next_history[15:8], taken_action[17:16],
    // reward[33:18], episode_end[34], greedy_only[35], random_draw[67:36]
    input  wire logic [tql_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: operation (0 choose, 1 learn)
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: chosen_action[1:0], explored[2], updated_value[26:3]
    output logic [tql_pkg::M_TDATA_W-1:0]        m_tdata
);

    tql_pkg::tql_cmd_t  cmd;
    tql_pkg::tql_stat_t st;

    tql_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tql_dp #(
        .HISTORY_BITS (HISTORY_BITS),
        .MAX_ACTIONS  (MAX_ACTIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

### src/tql_ctrl.sv
// Sequencing state machine for the tabular Q-learning engine.
// Depends on tql_pkg for the command and status structs.
`default_nettype none

module tql_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire tql_pkg::tql_stat_t st,
    output tql_pkg::tql_cmd_t       cmd
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH = 4'd2;
    localparam logic [3:0] ST_SCAN     = 4'd3;
    localparam logic [3:0] ST_RD_ONE   = 4'd4;
    localparam logic [3:0] ST_CAPTURE  = 4'd5;
    localparam logic [3:0] ST_MUL1     = 4'd6;
    localparam logic [3:0] ST_MUL2     = 4'd7;
    localparam logic [3:0] ST_WRITE    = 4'd8;
    localparam logic [3:0] ST_OUT      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (st.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!st.is_learn) begin
                    state_next = st.explore ? ST_RD_ONE : ST_SCAN;
                end else if (!st.taken_ok) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = st.ep_done ? ST_RD_ONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (st.scan_last) begin
                    state_next = st.is_learn ? ST_RD_ONE : ST_OUT;
                end
            end
            ST_RD_ONE: begin
                cmd.rd_one = 1'b1;
                state_next = ST_CAPTURE;
            end
            ST_CAPTURE: begin
                cmd.capture = 1'b1;
                state_next  = st.is_learn ? ST_MUL1 : ST_OUT;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Wait here only while the previous result is still unclaimed.
                if (!st.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/tql_dp.sv
// Datapath of the tabular Q-learning engine: configuration registers, Q table
// memory, row maximum scan, update arithmetic and the result register.
// Depends on tql_pkg; driven by tql_ctrl through command and status structs.
`default_nettype none

module tql_dp #(
    parameter int HISTORY_BITS = tql_pkg::DEF_HISTORY_BITS,
    parameter int MAX_ACTIONS  = tql_pkg::DEF_MAX_ACTIONS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tql_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tql_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [tql_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              s_tuser,
    input  wire tql_pkg::tql_cmd_t                 cmd,
    output tql_pkg::tql_stat_t                     st,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tql_pkg::M_TDATA_W-1:0]          m_tdata
);

    localparam int HB     = HISTORY_BITS;
    localparam int AW     = $clog2(MAX_ACTIONS);
    localparam int CW     = $clog2(MAX_ACTIONS + 1);
    localparam int ADDR_W = HB + AW;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int QW     = tql_pkg::Q_W;

    // Configuration registers.
    logic [2:0]  count_reg;
    logic [15:0] lr_reg;
    logic [15:0] disc_reg;
    logic [16:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= tql_pkg::RST_ACTION_COUNT;
            lr_reg    <= tql_pkg::RST_LEARN_RATE;
            disc_reg  <= tql_pkg::RST_DISCOUNT;
            thr_reg   <= tql_pkg::RST_EXPLORE_THR;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tql_pkg::CFG_ACTION_COUNT: count_reg <= cfg_wdata[2:0];
                tql_pkg::CFG_LEARN_RATE:   lr_reg    <= cfg_wdata[15:0];
                tql_pkg::CFG_DISCOUNT:     disc_reg  <= cfg_wdata[15:0];
                tql_pkg::CFG_EXPLORE_THR:  thr_reg   <= cfg_wdata[16:0];
            endcase
        end
    end

    // Active action count, clamped to one through MAX_ACTIONS.
    logic [CW-1:0] n_act;
    always_comb begin
        if (count_reg == 3'd0) begin
            n_act = CW'(1);
        end else if (32'(count_reg) > 32'(MAX_ACTIONS)) begin
            n_act = CW'(MAX_ACTIONS);
        end else begin
            n_act = CW'(count_reg);
        end
    end

    // Item fields decoded at the accept edge.
    logic [15:0]      draw_hi;
    logic [15:0]      draw_lo;
    logic             explore_in;
    logic [16+CW-1:0] ract_prod;
    logic [AW-1:0]    ract_in;

    assign draw_hi    = s_tdata[67:52];
    assign draw_lo    = s_tdata[51:36];
    assign explore_in = !s_tdata[35] && ({1'b0, draw_hi} < thr_reg);
    assign ract_prod  = (16+CW)'(draw_lo) * (16+CW)'(n_act);
    assign ract_in    = AW'(ract_prod[16+CW-1:16]);

    logic                   op_reg;
    logic [HB-1:0]          row_reg;
    logic [HB-1:0]          nrow_reg;
    logic [1:0]             taken_reg;
    logic signed [15:0]     reward_reg;
    logic                   done_reg;
    logic                   explore_reg;
    logic [AW-1:0]          ract_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_tuser;
            row_reg     <= HB'(s_tdata[7:0]);
            nrow_reg    <= HB'(s_tdata[15:8]);
            taken_reg   <= s_tdata[17:16];
            reward_reg  <= $signed(s_tdata[33:18]);
            done_reg    <= s_tdata[34];
            explore_reg <= explore_in;
            ract_reg    <= ract_in;
        end
    end

    logic taken_ok;
    assign taken_ok = (CW+2)'(taken_reg) < (CW+2)'(n_act);

    // Row scan: one read issued per cycle, compared when its data returns.
    logic [CW-1:0] scan_idx_reg;
    logic [CW-1:0] pend_idx_reg;
    logic          rd_pend_reg;
    logic          issue;
    logic [HB-1:0] scan_row;
    logic [AW-1:0] one_act;

    assign issue    = cmd.scan && (scan_idx_reg < n_act);
    assign scan_row = (op_reg == tql_pkg::OP_LEARN) ? nrow_reg : row_reg;
    assign one_act  = (op_reg == tql_pkg::OP_LEARN) ? AW'(taken_reg) : ract_reg;

    // Q table memory and its clearing pass.
    logic signed [QW-1:0] q_mem [0:DEPTH-1];
    logic signed [QW-1:0] rdata_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic signed [QW-1:0] wr_data;
    logic                 mem_we;
    logic                 mem_re;
    logic signed [QW-1:0] newq;

    assign rd_addr = cmd.scan ? {scan_row, scan_idx_reg[AW-1:0]} : {row_reg, one_act};
    assign mem_re  = issue || cmd.rd_one;
    assign mem_we  = cmd.clear || cmd.write;
    assign wr_addr = cmd.clear ? clr_addr_reg : {row_reg, AW'(taken_reg)};
    assign wr_data = cmd.clear ? '0 : newq;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            q_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rdata_reg <= q_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            rd_pend_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            rd_pend_reg <= issue;
        end
    end

    logic signed [QW-1:0] best_val_reg;
    logic [AW-1:0]        best_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            scan_idx_reg <= '0;
        end else if (issue) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (issue) begin
            pend_idx_reg <= scan_idx_reg;
        end
        // Strict compare keeps the first action among equal maxima.
        if (rd_pend_reg && ((pend_idx_reg == '0) || (rdata_reg > best_val_reg))) begin
            best_val_reg <= rdata_reg;
            best_idx_reg <= pend_idx_reg[AW-1:0];
        end
    end

    // Update arithmetic: g = round(discount * maxQ), d = round(lr * (r + g - Q)).
    logic signed [QW-1:0] cur_reg;
    logic signed [QW-1:0] nmax;
    logic signed [16:0]   disc_s;
    logic signed [16:0]   lr_s;
    logic signed [40:0]   prod1_next;
    logic signed [40:0]   prod1_reg;
    logic signed [40:0]   g_sum;
    logic signed [24:0]   g_val;
    logic signed [25:0]   target;
    logic signed [26:0]   diff;
    logic signed [43:0]   prod2_next;
    logic signed [43:0]   prod2_reg;
    logic signed [43:0]   d_sum;
    logic signed [27:0]   d_val;
    logic signed [28:0]   q_sum;
    logic signed [QW-1:0] newq_reg;

    assign nmax       = done_reg ? '0 : best_val_reg;
    assign disc_s     = $signed({1'b0, disc_reg});
    assign lr_s       = $signed({1'b0, lr_reg});
    assign prod1_next = 41'(disc_s) * 41'(nmax);
    assign g_sum      = prod1_reg + 41'sd32768;
    assign g_val      = $signed(g_sum[40:16]);
    assign target     = 26'(reward_reg) + 26'(g_val);
    assign diff       = 27'(target) - 27'(cur_reg);
    assign prod2_next = 44'(lr_s) * 44'(diff);
    assign d_sum      = prod2_reg + 44'sd32768;
    assign d_val      = $signed(d_sum[43:16]);
    assign q_sum      = 29'(cur_reg) + 29'(d_val);

    always_comb begin
        if (q_sum > 29'(tql_pkg::Q_MAX)) begin
            newq = tql_pkg::Q_MAX;
        end else if (q_sum < 29'(tql_pkg::Q_MIN)) begin
            newq = tql_pkg::Q_MIN;
        end else begin
            newq = q_sum[QW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_reg <= rdata_reg;
        end
        if (cmd.mul1) begin
            prod1_reg <= prod1_next;
        end
        if (cmd.mul2) begin
            prod2_reg <= prod2_next;
        end
        if (cmd.write) begin
            newq_reg <= newq;
        end
    end

    // Result register.
    logic                 m_tvalid_reg;
    logic [1:0]           res_act_reg;
    logic                 res_expl_reg;
    logic signed [QW-1:0] res_val_reg;
    logic [1:0]           act_sel;
    logic signed [QW-1:0] val_sel;

    always_comb begin
        if (op_reg == tql_pkg::OP_LEARN) begin
            act_sel = taken_reg;
            val_sel = taken_ok ? newq_reg : '0;
        end else if (explore_reg) begin
            act_sel = 2'(ract_reg);
            val_sel = cur_reg;
        end else begin
            act_sel = 2'(best_idx_reg);
            val_sel = best_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            res_act_reg  <= act_sel;
            res_expl_reg <= (op_reg == tql_pkg::OP_CHOOSE) && explore_reg;
            res_val_reg  <= val_sel;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, res_val_reg, res_expl_reg, res_act_reg};

    assign st.clear_last = (clr_addr_reg == '1);
    assign st.is_learn   = (op_reg == tql_pkg::OP_LEARN);
    assign st.explore    = explore_reg;
    assign st.taken_ok   = taken_ok;
    assign st.ep_done    = done_reg;
    assign st.scan_last  = rd_pend_reg && (pend_idx_reg == CW'(n_act - CW'(1)));
    assign st.out_busy   = m_tvalid_reg && !m_tready;

    // A table write comes only from a learn item whose action is in range.
    a_write_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> (op_reg == tql_pkg::OP_LEARN) && taken_ok)
        else $error("table write without a valid learn item");

    // The clearing pass never overlaps an item.
    a_clear_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !cmd.write && !cmd.load && !cmd.emit)
        else $error("clearing pass overlaps item work");

    // A pending scan read always belongs to an active action.
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (pend_idx_reg < n_act))
        else $error("scan read beyond the active actions");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
